/* design/rcg_pkg.sv */
// rcg_pkg: shared types and constants of the ring cadence generator
// no dependencies; used by the interfaces and every module in design/
`default_nettype none

package rcg_pkg;

  // field and timer widths
  localparam int unsigned CfgW   = 16;
  localparam int unsigned TimerW = 17;
  localparam int unsigned CountW = 8;
  localparam int unsigned MsW    = 8;
  localparam int unsigned IdxW   = 2;

  // operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // configuration register indexes
  localparam logic [IdxW-1:0] REG_BELL_ON  = 2'd0;
  localparam logic [IdxW-1:0] REG_BELL_OFF = 2'd1;
  localparam logic [IdxW-1:0] REG_BURST    = 2'd2;
  localparam logic [IdxW-1:0] REG_PAUSE    = 2'd3;

  // configuration reset values
  localparam logic [CfgW-1:0] BELL_ON_RST  = 16'd35;
  localparam logic [CfgW-1:0] BELL_OFF_RST = 16'd35;
  localparam logic [CfgW-1:0] BURST_RST    = 16'd2000;
  localparam logic [CfgW-1:0] PAUSE_RST    = 16'd4000;

  typedef struct packed {
    logic              operation;
    logic [MsW-1:0]    elapsed_ms;
    logic [CountW-1:0] ring_count;
  } cmd_t;

  typedef struct packed {
    logic              bell_drive;
    logic              busy_res;
    logic [CountW-1:0] rings_remaining;
  } res_t;

  typedef struct packed {
    logic [CfgW-1:0] bell_on_ms;
    logic [CfgW-1:0] bell_off_ms;
    logic [CfgW-1:0] burst_ms;
    logic [CfgW-1:0] pause_ms;
  } cfg_t;

  typedef struct packed {
    logic              ringing_active;
    logic [CountW-1:0] rings_left;
    logic [TimerW-1:0] cadence_timer;
    logic              burst_enable;
    logic [TimerW-1:0] toggle_timer;
    logic              bell_level;
  } state_t;

endpackage

`default_nettype wire

/* design/rcg_if.sv */
// rcg_if: valid/ready channel interfaces for command and result beats
// depends on rcg_pkg for field widths
`default_nettype none

interface rcg_cmd_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [rcg_pkg::MsW-1:0]    elapsed_ms;
  logic [rcg_pkg::CountW-1:0] ring_count;

  modport source (output valid, output operation, output elapsed_ms, output ring_count,
                  input ready);
  modport sink (input valid, input operation, input elapsed_ms, input ring_count,
                output ready);
endinterface

interface rcg_res_if;
  logic                      valid;
  logic                      ready;
  logic                      bell_drive;
  logic                      busy_res;
  logic [rcg_pkg::CountW-1:0] rings_remaining;

  modport source (output valid, output bell_drive, output busy_res,
                  output rings_remaining, input ready);
  modport sink (input valid, input bell_drive, input busy_res, input rings_remaining,
                output ready);
endinterface

`default_nettype wire

/* design/rcg_cfg.sv */
// rcg_cfg: configuration register bank (bell on/off, burst and pause times)
// depends on rcg_pkg
`default_nettype none

module rcg_cfg (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [rcg_pkg::IdxW-1:0] cfg_index,
  input  wire logic [rcg_pkg::CfgW-1:0] cfg_data,
  output rcg_pkg::cfg_t                 cfg
);

  // register writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bell_on_ms  <= rcg_pkg::BELL_ON_RST;
      cfg.bell_off_ms <= rcg_pkg::BELL_OFF_RST;
      cfg.burst_ms    <= rcg_pkg::BURST_RST;
      cfg.pause_ms    <= rcg_pkg::PAUSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rcg_pkg::REG_BELL_ON:  cfg.bell_on_ms  <= cfg_data;
        rcg_pkg::REG_BELL_OFF: cfg.bell_off_ms <= cfg_data;
        rcg_pkg::REG_BURST:    cfg.burst_ms    <= cfg_data;
        rcg_pkg::REG_PAUSE:    cfg.pause_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/rcg_engine.sv */
// rcg_engine: cadence state registers and the one-pass update for a command beat
// depends on rcg_pkg
`default_nettype none

module rcg_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  rcg_pkg::cmd_t       cmd,
  input  rcg_pkg::cfg_t       cfg,
  output rcg_pkg::res_t       res_next,
  output rcg_pkg::state_t     state
);

  rcg_pkg::state_t state_next;
  logic [rcg_pkg::TimerW-1:0] dt;
  logic [rcg_pkg::TimerW-1:0] cad_sum;
  logic [rcg_pkg::TimerW-1:0] tog_sum;

  assign dt = {{(rcg_pkg::TimerW - rcg_pkg::MsW){1'b0}}, cmd.elapsed_ms};

  // start load, then cadence and toggle timers
  always_comb begin
    state_next = state;
    cad_sum    = '0;
    tog_sum    = '0;
    if (cmd.operation == rcg_pkg::OP_START) begin
      state_next.rings_left     = cmd.ring_count;
      state_next.bell_level     = 1'b1;
      state_next.ringing_active = 1'b1;
    end
    if (state_next.ringing_active && (state_next.rings_left != '0)) begin
      // cadence: burst and pause phases
      cad_sum = state_next.cadence_timer + dt;
      state_next.cadence_timer = cad_sum;
      if (state_next.burst_enable) begin
        if (cad_sum > {1'b0, cfg.burst_ms}) begin
          state_next.cadence_timer = '0;
          state_next.burst_enable  = 1'b0;
          state_next.rings_left    = state_next.rings_left - rcg_pkg::CountW'(1);
          if (state_next.rings_left == '0) begin
            state_next.ringing_active = 1'b0;
            state_next.bell_level     = 1'b0;
          end
        end
      end else if (cad_sum > {1'b0, cfg.pause_ms}) begin
        state_next.cadence_timer = '0;
        state_next.burst_enable  = 1'b1;
      end
      // toggle: chop the bell within a burst
      tog_sum = state_next.toggle_timer + dt;
      state_next.toggle_timer = tog_sum;
      if (state_next.bell_level) begin
        if (tog_sum > {1'b0, cfg.bell_on_ms}) begin
          state_next.toggle_timer = '0;
          state_next.bell_level   = 1'b0;
        end
      end else if (tog_sum > {1'b0, cfg.bell_off_ms}) begin
        state_next.toggle_timer = '0;
        if (state_next.burst_enable) begin
          state_next.bell_level = 1'b1;
        end
      end
    end
  end

  assign res_next.bell_drive      = state_next.bell_level;
  assign res_next.busy_res        = state_next.ringing_active;
  assign res_next.rings_remaining = state_next.rings_left;

  // state update once per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* design/ring_cadence_generator_core.sv */
// ring_cadence_generator_core: top level, input register, engine and result register
// depends on rcg_pkg, rcg_if.sv, rcg_cfg and rcg_engine
`default_nettype none

// Telephone ring cadence generator. Each command beat is a tick or a start
// and carries the milliseconds elapsed; every beat yields exactly one result
// beat with the bell level, the busy flag and the bursts still to ring.
// A beat is captured in an input register, passes the timer update and
// lands in a result register, so one beat per cycle is sustained while
// results are read; each result passes both registers on its way out. The
// input register is freed whenever the result register is empty or being
// read; a result that waits keeps the next beat in the input register, and
// that beat stops further commands until the result is read.
// Configuration writes take effect at the next edge; write only while idle.
module ring_cadence_generator_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  rcg_cmd_if.sink                       cmd,
  rcg_res_if.source                     res,
  input  wire logic                     cfg_we,
  input  wire logic [rcg_pkg::IdxW-1:0] cfg_index,
  input  wire logic [rcg_pkg::CfgW-1:0] cfg_data
);

  logic            cmd_valid;
  rcg_pkg::cmd_t   cmd_reg;
  logic            res_valid;
  rcg_pkg::res_t   res_reg;
  rcg_pkg::res_t   res_next;
  rcg_pkg::cfg_t   cfg;
  rcg_pkg::state_t state;
  logic            step;

  assign step      = cmd_valid && (!res_valid || res.ready);
  assign cmd.ready = !cmd_valid || step;

  rcg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcg_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cmd      (cmd_reg),
    .cfg      (cfg),
    .res_next (res_next),
    .state    (state)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd.ready) begin
      cmd_valid <= cmd.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_reg.operation  <= cmd.operation;
      cmd_reg.elapsed_ms <= cmd.elapsed_ms;
      cmd_reg.ring_count <= cmd.ring_count;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= res_next;
    end
  end

  assign res.valid           = res_valid;
  assign res.bell_drive      = res_reg.bell_drive;
  assign res.busy_res        = res_reg.busy_res;
  assign res.rings_remaining = res_reg.rings_remaining;

  // the bell never rings while the sequence is inactive
  a_bell_needs_active: assert property (@(posedge clk) disable iff (rst)
    !state.ringing_active |-> !state.bell_level)
    else $error("bell high while ring sequence inactive");

  // an inactive block has no bursts left
  a_idle_no_rings: assert property (@(posedge clk) disable iff (rst)
    !state.ringing_active |-> (state.rings_left == '0))
    else $error("rings left while ring sequence inactive");

  // an accepted command beat occupies the input register next cycle
  a_cmd_captured: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> cmd_valid)
    else $error("accepted command beat was lost");

  // a result beat is produced whenever the engine steps
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> res_valid)
    else $error("engine step without result beat");

endmodule

`default_nettype wire

/* sim/ring_cadence_generator_core_tb.sv */
// ring_cadence_generator_core_tb: self-checking bench for the ring cadence generator core
// needs rcg_pkg, rcg_if.sv and ring_cadence_generator_core from design/
`timescale 1ns / 1ps

module ring_cadence_generator_core_tb;
  import rcg_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic            cfg_we;
  logic [IdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  rcg_cmd_if cmd_ch ();
  rcg_res_if res_ch ();

  ring_cadence_generator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted cadence settings
  logic [CfgW-1:0] on_ms, off_ms, burst_len, pause_len;

  // predicted ringer state
  logic              active_q;
  logic [CountW-1:0] rings_q;
  logic [TimerW-1:0] cad_tmr;
  logic              burst_on;
  logic [TimerW-1:0] tog_tmr;
  logic              bell_q;

  res_t status_q[$];
  res_t want_r, got_r;
  int   err_cnt = 0;
  bit   idle_en = 1'b0;

  // one beat through the ringer: start load, then the cadence and toggle timers
  function automatic res_t cadence_predict(input cmd_t c);
    res_t r;
    if (c.operation == OP_START) begin
      rings_q  = c.ring_count;
      bell_q   = 1'b1;
      active_q = 1'b1;
    end
    if (active_q && rings_q != '0) begin
      cad_tmr = cad_tmr + {9'd0, c.elapsed_ms};
      if (burst_on) begin
        if (cad_tmr > {1'b0, burst_len}) begin
          cad_tmr  = '0;
          burst_on = 1'b0;
          rings_q  = rings_q - 8'd1;
          if (rings_q == '0) begin
            active_q = 1'b0;
            bell_q   = 1'b0;
          end
        end
      end else if (cad_tmr > {1'b0, pause_len}) begin
        cad_tmr  = '0;
        burst_on = 1'b1;
      end
      tog_tmr = tog_tmr + {9'd0, c.elapsed_ms};
      if (bell_q) begin
        if (tog_tmr > {1'b0, on_ms}) begin
          tog_tmr = '0;
          bell_q  = 1'b0;
        end
      end else if (tog_tmr > {1'b0, off_ms}) begin
        tog_tmr = '0;
        if (burst_on) bell_q = 1'b1;
      end
    end
    r.bell_drive      = bell_q;
    r.busy_res        = active_q;
    r.rings_remaining = rings_q;
    return r;
  endfunction

  // predict on every accepted command beat
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready)
      status_q.push_back(cadence_predict({cmd_ch.operation, cmd_ch.elapsed_ms,
                                          cmd_ch.ring_count}));
  end

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    err_cnt++;
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_r = {res_ch.bell_drive, res_ch.busy_res, res_ch.rings_remaining};
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got bell %0d busy %0d rings %0d",
                 $time, got_r.bell_drive, got_r.busy_res, got_r.rings_remaining);
        err_cnt++;
      end else begin
        want_r = status_q.pop_front();
        if (got_r.bell_drive !== want_r.bell_drive)
          report_field("bell_drive", want_r.bell_drive, got_r.bell_drive);
        if (got_r.busy_res !== want_r.busy_res)
          report_field("busy_res", want_r.busy_res, got_r.busy_res);
        if (got_r.rings_remaining !== want_r.rings_remaining)
          report_field("rings_remaining", want_r.rings_remaining, got_r.rings_remaining);
      end
    end
  end

  // result side back-pressure in random bursts
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  // drive one command beat and hold it until taken
  task automatic send_beat(input logic op, input logic [MsW-1:0] dt,
                           input logic [CountW-1:0] cnt);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.operation  <= op;
    cmd_ch.elapsed_ms <= dt;
    cmd_ch.ring_count <= cnt;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // stop sending and wait until every predicted beat has come back
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_BELL_ON:  on_ms     = val;
      REG_BELL_OFF: off_ms    = val;
      REG_BURST:    burst_len = val;
      REG_PAUSE:    pause_len = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_cadence(input logic [CfgW-1:0] on_v, input logic [CfgW-1:0] off_v,
                              input logic [CfgW-1:0] burst_v, input logic [CfgW-1:0] pause_v);
    write_reg(REG_BELL_ON, on_v);
    write_reg(REG_BELL_OFF, off_v);
    write_reg(REG_BURST, burst_v);
    write_reg(REG_PAUSE, pause_v);
  endtask

  // mostly ticks with a start now and then, counts biased small so rings finish
  task automatic send_random_beat();
    int sel;
    logic [MsW-1:0]    dt;
    logic [CountW-1:0] cnt;
    sel = $urandom_range(0, 9);
    dt  = (sel == 0) ? 8'd0 : (sel == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 8) begin
      sel = $urandom_range(0, 9);
      cnt = (sel == 0) ? 8'd0 : (sel == 1) ? 8'hFF :
            (sel == 2) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 3));
      send_beat(OP_START, dt, cnt);
    end else begin
      send_beat(OP_TICK, dt, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_inactive_ticks();
    send_beat(OP_TICK, 8'd0, 8'd0);
    send_beat(OP_TICK, 8'hFF, 8'hFF);
  endtask

  // count zero keeps the bell high and the sequence busy
  task automatic test_start_count_zero();
    send_beat(OP_START, 8'hFF, 8'd0);
    send_beat(OP_TICK, 8'hFF, 8'd0);
    send_beat(OP_TICK, 8'd0, 8'hAA);
  endtask

  // a start while busy reloads the count and keeps the timers
  task automatic test_restart_while_active();
    send_beat(OP_START, 8'd0, 8'hFF);
    repeat (3) send_beat(OP_TICK, 8'hFF, 8'h55);
    send_beat(OP_START, 8'd128, 8'd3);
    send_beat(OP_TICK, 8'hFF, 8'd0);
    drain_results();
  endtask

  // all timers zero: every nonzero tick flips phase, the ring ends fast
  task automatic test_zero_timers();
    load_cadence(16'd0, 16'd0, 16'd0, 16'd0);
    send_beat(OP_START, 8'd1, 8'd2);
    send_beat(OP_TICK, 8'd0, 8'd0);
    repeat (5) send_beat(OP_TICK, 8'd1, 8'd0);
    drain_results();
  endtask

  task automatic test_max_timers();
    load_cadence(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(OP_START, 8'hFF, 8'd1);
    repeat (3) send_beat(OP_TICK, 8'hFF, 8'd0);
    drain_results();
  endtask

  // several cadence settings, each with a burst of random beats
  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: load_cadence(BELL_ON_RST, BELL_OFF_RST, BURST_RST, PAUSE_RST);
        2: load_cadence(16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
                        16'($urandom_range(100, 1500)), 16'($urandom_range(100, 1500)));
        3: load_cadence(16'($urandom), 16'($urandom),
                        16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)));
        4: load_cadence(16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
                        16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)));
        5: load_cadence(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                        16'hFFFF, 16'($urandom_range(0, 300)));
        6: load_cadence(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: load_cadence(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                              16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)));
      endcase
      idle_en = (p % 3 != 2);
      send_beat(OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(1, 3)));
      repeat (120) send_random_beat();
      drain_results();
    end
  endtask

  // back-to-back beats with no idling on either side
  task automatic test_streaming();
    load_cadence(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                 16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)));
    idle_en = 1'b0;
    send_beat(OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(1, 3)));
    repeat (130) send_random_beat();
    drain_results();
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_BELL_ON;
    cfg_data          <= '0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.operation  <= OP_TICK;
    cmd_ch.elapsed_ms <= '0;
    cmd_ch.ring_count <= '0;
    on_ms     = BELL_ON_RST;
    off_ms    = BELL_OFF_RST;
    burst_len = BURST_RST;
    pause_len = PAUSE_RST;
    active_q  = 1'b0;
    rings_q   = '0;
    cad_tmr   = '0;
    burst_on  = 1'b0;
    tog_tmr   = '0;
    bell_q    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_inactive_ticks();
    test_start_count_zero();
    test_restart_while_active();
    test_zero_timers();
    test_max_timers();
    test_random_phases();
    test_streaming();

    if (err_cnt == 0 && status_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
